[sv/pse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants
// Token codes, status codes and the controller-to-datapath command set.
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int unsigned DEPTH   = 16;
	localparam int unsigned PTR_W   = $clog2(DEPTH);
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned DATA_W  = 32;

	typedef enum logic [2:0] {
		TOK_PUSH = 3'd0,
		TOK_ADD  = 3'd1,
		TOK_SUB  = 3'd2,
		TOK_MUL  = 3'd3,
		TOK_DIV  = 3'd4,
		TOK_POW  = 3'd5,
		TOK_MOD  = 3'd6,
		TOK_NONE = 3'd7
	} tok_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  load;      // capture the input token
		logic  rd_ops;    // read the two top entries
		logic  start;     // start the arithmetic with the read operands
		logic  step;      // run one iteration of the iterative unit
		logic  commit;    // write the result and update the count
		logic  report;    // load the result register
		logic  reject;    // status only, stack unchanged
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic  is_push;
		logic  is_op;
		logic  full;
		logic  few;
		logic  div_zero;
		logic  iter_done;
		logic  iterative;
	} sts_t;

endpackage : pse_pkg
`default_nettype wire

[sv/postfix_stack_evaluator_unit.sv]
`default_nettype none
// Sequencing: push, the unused token kind and underflow go from decode straight
// to write-back; add/sub/mul, a zero divisor and power with a negative
// exponent also pass read and calc. Div and mod run 32 iterations of a restoring
// divider in calc; power runs 31 square-and-multiply iterations there.
// Throughput: one token at a time; the next is accepted from the cycle its
// result beat is loaded, and a beat still waiting holds the next in report.
// Reset empties the stack; entries are not cleared.
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit: RPN token evaluator
// A sequencer drives a datapath holding a 16-entry operand stack and an
// iterative arithmetic unit shared by divide, modulo and power.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit import pse_pkg::*; (
	input  wire  logic               clk,
	input  wire  logic               arst_n,
	input  wire  logic               in_valid,
	output logic                     in_ready,
	input  wire  logic [2:0]         func,
	input  wire  logic signed [31:0] operand_value,
	output logic                     out_valid,
	input  wire  logic               out_ready,
	output logic signed [31:0]       top_value,
	output logic [4:0]               stack_depth,
	output logic [1:0]               status
);

	cmd_t cmd;
	sts_t sts;
	logic out_full_q;

	// The controller only issues a report once the output register is free.
	pse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_full (out_full_q),
		.sts      (sts),
		.cmd      (cmd)
	);

	pse_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.func          (func),
		.operand_value (operand_value),
		.cmd           (cmd),
		.sts           (sts),
		.res_top       (top_value),
		.res_depth     (stack_depth),
		.res_status    (status)
	);

	// The output register holds the result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)            out_full_q <= 1'b0;
		else if (cmd.report)    out_full_q <= 1'b1;
		else if (out_ready)     out_full_q <= 1'b0;
	end

	assign out_valid = out_full_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |-> !out_full_q) else $error("result overwritten");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result beat dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("second token accepted");
`endif

endmodule : postfix_stack_evaluator_unit
`default_nettype wire

[sv/pse_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pse_ctrl: token sequencer
// One-hot state machine that steps each token through decode, read and
// compute (operators with two operands only), write-back and report.
// ----------------------------------------------------------------------------
module pse_ctrl import pse_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic in_valid,
	output logic       in_ready,
	input  wire  logic out_full,
	input  wire  sts_t sts,
	output cmd_t       cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DEC   = 6'b000010,
		S_READ  = 6'b000100,
		S_CALC  = 6'b001000,
		S_WB    = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_push) begin
					if (sts.full) cmd.reject = 1'b1;
					state_d = S_WB;
				end else if (sts.is_op) begin
					if (sts.few) begin
						cmd.reject = 1'b1;
						state_d    = S_WB;
					end else begin
						cmd.rd_ops = 1'b1;
						state_d    = S_READ;
					end
				end else begin
					state_d = S_WB;
				end
			end
			S_READ: begin
				cmd.start = 1'b1;
				state_d   = S_CALC;
			end
			S_CALC: begin
				if (sts.div_zero) begin
					cmd.reject = 1'b1;
					state_d    = S_WB;
				end else if (!sts.iterative || sts.iter_done) begin
					state_d = S_WB;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_WB: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!out_full) begin
					cmd.report = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state not one-hot");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_ready) else $error("token loaded outside idle");
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (state_q == S_OUT)) else $error("commit not followed by report");
`endif

endmodule : pse_ctrl
`default_nettype wire

[sv/pse_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pse_dp: stack and arithmetic datapath
// Operand memory, entry count, combinational add/sub/mul and a shared
// iterative divide and power unit.
// ----------------------------------------------------------------------------
module pse_dp import pse_pkg::*; (
	input  wire  logic               clk,
	input  wire  logic               arst_n,
	input  wire  logic [2:0]         func,
	input  wire  logic signed [31:0] operand_value,
	input  wire  cmd_t               cmd,
	output sts_t                     sts,
	output logic signed [31:0]       res_top,
	output logic [CNT_W-1:0]         res_depth,
	output logic [1:0]               res_status
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [2:0]        func_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] lhs_q, rhs_q, top_q;
	logic [1:0]        status_q;

	// Iterative unit state: shared by divide (restoring) and power.
	logic [DATA_W-1:0] acc_q;   // remainder or running product
	logic [DATA_W-1:0] aux_q;   // quotient bits or square
	logic [DATA_W-1:0] ex_q;    // dividend magnitude or exponent
	logic [5:0]        it_q;
	logic              neg_q, rneg_q;

	logic [DATA_W-1:0] dmag;
	logic [DATA_W:0]   trial;
	logic [DATA_W-1:0] quo, rem, fast_res, result;
	logic [PTR_W-1:0]  top_idx, nxt_idx;

	always_comb begin
		sts           = '0;
		sts.is_push   = (func_q == TOK_PUSH);
		sts.is_op     = (func_q != TOK_PUSH) && (func_q != TOK_NONE);
		sts.full      = (cnt_q >= CNT_W'(DEPTH));
		sts.few       = (cnt_q < CNT_W'(2));
		sts.div_zero  = ((func_q == TOK_DIV) || (func_q == TOK_MOD)) && (rhs_q == '0);
		sts.iterative = (func_q == TOK_DIV) || (func_q == TOK_MOD) || (func_q == TOK_POW);
		sts.iter_done = (it_q == 6'd0);
	end

	assign dmag    = rhs_q[31] ? (~rhs_q + 32'd1) : rhs_q;
	assign trial   = {acc_q, ex_q[31]} - {1'b0, dmag};
	assign top_idx = PTR_W'(cnt_q - CNT_W'(1));
	assign nxt_idx = PTR_W'(cnt_q - CNT_W'(2));

	always_comb begin
		case (func_q)
			TOK_ADD: fast_res = lhs_q + rhs_q;
			TOK_SUB: fast_res = lhs_q - rhs_q;
			default: fast_res = 32'(lhs_q * rhs_q);
		endcase
	end

	assign quo = neg_q  ? (~aux_q + 32'd1) : aux_q;
	assign rem = rneg_q ? (~acc_q + 32'd1) : acc_q;

	always_comb begin
		case (func_q)
			TOK_DIV: result = quo;
			TOK_MOD: result = rem;
			TOK_POW: result = acc_q;
			default: result = fast_res;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			val_q  <= operand_value;
		end
		if (cmd.rd_ops) begin
			rhs_q <= mem_q[top_idx];
			lhs_q <= mem_q[nxt_idx];
		end
		if (cmd.start) begin
			if (func_q == TOK_POW) begin
				aux_q <= lhs_q;
				ex_q  <= rhs_q;
				if (rhs_q[31]) begin
					it_q  <= 6'd0;
					if (lhs_q == 32'd1)           acc_q <= 32'd1;
					else if (lhs_q == '1)          acc_q <= rhs_q[0] ? '1 : 32'd1;
					else                           acc_q <= '0;
				end else begin
					acc_q <= 32'd1;
					it_q  <= 6'd31;
				end
			end else begin
				acc_q  <= '0;
				aux_q  <= '0;
				ex_q   <= lhs_q[31] ? (~lhs_q + 32'd1) : lhs_q;
				neg_q  <= lhs_q[31] ^ rhs_q[31];
				rneg_q <= lhs_q[31];
				it_q   <= 6'd32;
			end
		end
		if (cmd.step) begin
			it_q <= it_q - 6'd1;
			if (func_q == TOK_POW) begin
				if (ex_q[0]) acc_q <= 32'(acc_q * aux_q);
				aux_q <= 32'(aux_q * aux_q);
				ex_q  <= ex_q >> 1;
			end else begin
				ex_q <= ex_q << 1;
				if (!trial[DATA_W]) begin
					acc_q <= trial[DATA_W-1:0];
					aux_q <= {aux_q[30:0], 1'b1};
				end else begin
					acc_q <= {acc_q[30:0], ex_q[31]};
					aux_q <= {aux_q[30:0], 1'b0};
				end
			end
		end
		if (cmd.commit && !cmd.reject && status_q == ST_OK) begin
			if (func_q == TOK_PUSH) mem_q[PTR_W'(cnt_q)] <= val_q;
			else if (func_q != TOK_NONE) mem_q[nxt_idx] <= result;
		end
		if (cmd.report) begin
			res_top    <= top_q;
			res_depth  <= cnt_q;
			res_status <= status_q;
		end
	end

	// Status is settled before commit; a reject in decode or calc sets it.
	// An operator is only rejected in decode for a short stack, and only in
	// calc for a zero divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			status_q <= ST_OK;
		end else begin
			if (cmd.load) status_q <= ST_OK;
			if (cmd.reject) begin
				if (sts.is_push)        status_q <= ST_OVERFLOW;
				else if (sts.few)       status_q <= ST_UNDERFLOW;
				else                    status_q <= ST_DIVZERO;
			end
			if (cmd.commit && status_q == ST_OK) begin
				if (func_q == TOK_PUSH)      cnt_q <= cnt_q + CNT_W'(1);
				else if (func_q != TOK_NONE) cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Top of stack for the report, tracked at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (cmd.commit && status_q == ST_OK) begin
			if (func_q == TOK_PUSH)      top_q <= val_q;
			else if (func_q != TOK_NONE) top_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH)) else $error("entry count beyond depth");
	a_div_iter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (it_q != 6'd0)) else $error("step past end");
	a_empty_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && status_q == ST_OK && func_q != TOK_PUSH && func_q != TOK_NONE)
		|-> (cnt_q >= CNT_W'(2))) else $error("operator committed on short stack");
`endif

endmodule : pse_dp
`default_nettype wire
